[src/pmba_pkg.sv]
// Shared constants, codes and control types of the power monitor block averager.
// Used by the controller, the datapath and the top level.
`default_nettype none

package pmba_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int COUNT_BITS    = 16;
   localparam int SUM_BITS      = 32;
   localparam int FRAC_BITS     = 8;
   localparam int GAIN_BITS     = 16;
   localparam int AVG_BITS      = 24;
   localparam int POWER_BITS    = 2 * AVG_BITS;
   localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
   localparam int PROD_BITS     = DIVIDEND_BITS + GAIN_BITS;
   localparam int DIV_STEP_BITS = $clog2(DIVIDEND_BITS);
   localparam int CHAN_COUNT    = 3;
   localparam int CHAN_BITS     = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int REQ_DATA_BITS = 3 * SAMPLE_BITS;
   localparam int RSP_DATA_BITS = 3 * AVG_BITS + POWER_BITS;
   localparam int RSP_USER_BITS = 2;

   localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1 << FRAC_BITS);

   // Item kinds carried on req_tuser.
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_TICK   = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLTAGE_GAIN     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CURRENT_GAIN     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEMPERATURE_GAIN = 2'd2;

   typedef logic [CHAN_BITS-1:0] chan_type;

   localparam chan_type CHAN_VOLTAGE     = 2'd0;
   localparam chan_type CHAN_CURRENT     = 2'd1;
   localparam chan_type CHAN_TEMPERATURE = 2'd2;

   typedef struct packed {
      logic     acc;        // add the accepted sample word to the sums
      logic     div_load;   // load the divider with the selected sum
      logic     div_step;   // one restoring division step
      logic     mul_cap;    // register quotient times gain
      logic     store;      // saturate and keep the scaled mean
      logic     pwr_cap;    // register the power product
      logic     out_load;   // load the result register and clear the window
      chan_type ch;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

[src/pmba_ctrl.sv]
// Controller of the block averager: sequences accumulation, the shared divider,
// scaling, the power product and the result load. Depends on pmba_pkg.
`default_nettype none

module pmba_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic             req_tuser,
   input  wire pmba_pkg::sts_type sts,
   output pmba_pkg::cmd_type     cmd
);
   import pmba_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_LOAD,
      S_DIV,
      S_SCALE,
      S_STORE,
      S_POWER,
      S_DONE
   } state_type;

   state_type                state_ff;
   logic [DIV_STEP_BITS-1:0] step_ff;
   chan_type                 ch_ff;
   logic                     accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd          = '0;
      cmd.ch       = ch_ff;
      cmd.acc      = accept && (req_tuser == FUNC_SAMPLE);
      cmd.div_load = (state_ff == S_DIV_LOAD);
      cmd.div_step = (state_ff == S_DIV);
      cmd.mul_cap  = (state_ff == S_SCALE);
      cmd.store    = (state_ff == S_STORE);
      cmd.pwr_cap  = (state_ff == S_POWER);
      cmd.out_load = (state_ff == S_DONE) && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         ch_ff    <= CHAN_VOLTAGE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept && (req_tuser == FUNC_TICK)) begin
                  ch_ff    <= CHAN_VOLTAGE;
                  state_ff <= sts.count_zero ? S_DONE : S_DIV_LOAD;
               end
            end
            S_DIV_LOAD: begin
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               step_ff <= step_ff + DIV_STEP_BITS'(1);
               if (step_ff == DIV_STEP_BITS'(DIVIDEND_BITS - 1)) begin
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               state_ff <= S_STORE;
            end
            S_STORE: begin
               if (ch_ff == CHAN_TEMPERATURE) begin
                  state_ff <= S_POWER;
               end else begin
                  ch_ff    <= ch_ff + CHAN_BITS'(1);
                  state_ff <= S_DIV_LOAD;
               end
            end
            S_POWER: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (sts.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[src/pmba_datapath.sv]
// Datapath of the block averager: sums, sample count, gain registers, a shared
// restoring divider, the scaling multiplier and the result register. Depends on pmba_pkg.
`default_nettype none

module pmba_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire pmba_pkg::cmd_type                      cmd,
   output pmba_pkg::sts_type                           sts,
   input  wire logic [pmba_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   input  wire logic                                   csr_write,
   input  wire logic [pmba_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [pmba_pkg::GAIN_BITS-1:0]         csr_data,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [pmba_pkg::RSP_DATA_BITS-1:0]          rsp_tdata,
   output logic [pmba_pkg::RSP_USER_BITS-1:0]          rsp_tuser
);
   import pmba_pkg::*;

   logic [SUM_BITS-1:0]      sum_ff [CHAN_COUNT];
   logic [COUNT_BITS-1:0]    count_ff;
   logic                     drop_ff;
   logic [GAIN_BITS-1:0]     gain_ff [CHAN_COUNT];

   logic [DIVIDEND_BITS-1:0] quo_ff;
   logic [COUNT_BITS-1:0]    rem_ff;
   logic [PROD_BITS-1:0]     prod_ff;
   logic [AVG_BITS-1:0]      avg_ff [CHAN_COUNT];
   logic [POWER_BITS-1:0]    pwr_ff;

   logic                     valid_ff;
   logic [RSP_DATA_BITS-1:0] data_ff;
   logic [RSP_USER_BITS-1:0] user_ff;

   logic [SAMPLE_BITS-1:0]   sample [CHAN_COUNT];
   logic [SUM_BITS:0]        sum_in [CHAN_COUNT];
   logic                     overflow;
   logic [COUNT_BITS:0]      trial;
   logic [COUNT_BITS:0]      diff;
   logic                     no_borrow;
   logic [PROD_BITS-FRAC_BITS-1:0] scaled;

   always_comb begin
      overflow = (count_ff == {COUNT_BITS{1'b1}});
      for (int i = 0; i < CHAN_COUNT; i++) begin
         sample[i] = req_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
         sum_in[i] = {1'b0, sum_ff[i]} + (SUM_BITS + 1)'(sample[i]);
         overflow  = overflow | sum_in[i][SUM_BITS];
      end
   end

   // One quotient bit per step; the partial remainder always stays below the count.
   assign trial     = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff      = trial - {1'b0, count_ff};
   assign no_borrow = !diff[COUNT_BITS];
   assign scaled    = prod_ff[PROD_BITS-1:FRAC_BITS];

   assign sts.count_zero = (count_ff == '0);
   assign sts.out_free   = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHAN_COUNT; i++) begin
            sum_ff[i] <= '0;
         end
         count_ff <= '0;
         drop_ff  <= 1'b0;
         valid_ff <= 1'b0;
         gain_ff[CHAN_VOLTAGE]     <= GAIN_UNITY;
         gain_ff[CHAN_CURRENT]     <= GAIN_UNITY;
         gain_ff[CHAN_TEMPERATURE] <= GAIN_UNITY;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_VOLTAGE_GAIN:     gain_ff[CHAN_VOLTAGE]     <= csr_data;
               CSR_CURRENT_GAIN:     gain_ff[CHAN_CURRENT]     <= csr_data;
               CSR_TEMPERATURE_GAIN: gain_ff[CHAN_TEMPERATURE] <= csr_data;
               default: ;
            endcase
         end

         if (cmd.out_load) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end

         if (cmd.out_load) begin
            for (int i = 0; i < CHAN_COUNT; i++) begin
               sum_ff[i] <= '0;
            end
            count_ff <= '0;
            drop_ff  <= 1'b0;
         end else if (cmd.acc) begin
            // A sample that arrives with the count full or that would carry a sum is dropped whole.
            if (overflow) begin
               drop_ff <= 1'b1;
            end else begin
               for (int i = 0; i < CHAN_COUNT; i++) begin
                  sum_ff[i] <= sum_in[i][SUM_BITS-1:0];
               end
               count_ff <= count_ff + COUNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quo_ff <= {sum_ff[cmd.ch], {FRAC_BITS{1'b0}}};
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[DIVIDEND_BITS-2:0], no_borrow};
         rem_ff <= no_borrow ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      end

      if (cmd.mul_cap) begin
         prod_ff <= PROD_BITS'(quo_ff) * PROD_BITS'(gain_ff[cmd.ch]);
      end

      if (cmd.store) begin
         if (scaled[PROD_BITS-FRAC_BITS-1:AVG_BITS] != '0) begin
            avg_ff[cmd.ch] <= {AVG_BITS{1'b1}};
         end else begin
            avg_ff[cmd.ch] <= scaled[AVG_BITS-1:0];
         end
      end

      // The product of two 24-bit means always fits the 48-bit power field.
      if (cmd.pwr_cap) begin
         pwr_ff <= POWER_BITS'(avg_ff[CHAN_VOLTAGE]) * POWER_BITS'(avg_ff[CHAN_CURRENT]);
      end

      if (cmd.out_load) begin
         if (count_ff == '0) begin
            data_ff <= '0;
         end else begin
            data_ff <= {pwr_ff, avg_ff[CHAN_TEMPERATURE], avg_ff[CHAN_CURRENT],
                        avg_ff[CHAN_VOLTAGE]};
         end
         user_ff <= {drop_ff, (count_ff == '0)};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

`default_nettype wire

[src/power_monitor_block_averager_unit.sv]
// Power monitor block averager, top level: controller plus datapath.
// Depends on pmba_pkg, pmba_ctrl and pmba_datapath.
//
// Usage:
//   The req channel carries one word per item. req_tuser is the kind: a sample
//   adds the three readings in req_tdata to the window sums and count; a
//   period tick closes the window and produces one rsp word.
//   A sample is taken and the block is ready again at once.
//   When the window holds samples, a tick runs the one shared divider, which
//   produces a quotient bit per cycle for each of the three channels in turn,
//   before rsp_tvalid; an empty window skips the arithmetic and goes to the load.
//   req_tready stays low from the tick's acceptance until the rsp word is loaded.
//   The rsp word sits in an output register; samples are still accepted while
//   it waits. A following tick completes its arithmetic and then waits for the
//   register to drain, so a stalled receiver loses nothing.
//   The csr channel writes the three gains (index 0 voltage, 1 current,
//   2 temperature) and is always ready; other indexes are ignored.
//   Synchronous reset clears the sums, count, drop flag and rsp_tvalid and sets
//   every gain to unity.
`default_nettype none

module power_monitor_block_averager_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [15:0] voltage_sample, [31:16] current_sample, [47:32] temperature_sample
   input  wire logic [pmba_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [0] func
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [23:0] avg_voltage, [47:24] avg_current, [71:48] avg_temperature,
   // [119:72] power_product
   output logic [pmba_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   // [0] window_empty, [1] samples_dropped
   output logic [pmba_pkg::RSP_USER_BITS-1:0]       rsp_tuser,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pmba_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [pmba_pkg::GAIN_BITS-1:0]      csr_data
);
   import pmba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   pmba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   pmba_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

[src/pmba_checker.sv]
// Port-level checks of the block averager, bound to the top level.
// Depends on pmba_pkg and power_monitor_block_averager_unit.
`default_nettype none

module pmba_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                req_tuser,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [pmba_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input wire logic [pmba_pkg::RSP_USER_BITS-1:0]  rsp_tuser
);
   import pmba_pkg::*;

   // A stalled result word must stay offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word withdrawn while stalled");

   // Reset empties the result register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // An empty window reports all values as zero.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("empty window with nonzero values");

   // A tick occupies the block, so no item is taken in the next cycle.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == FUNC_TICK) |=> !req_tready)
      else $error("item taken right after a period tick");

endmodule

bind power_monitor_block_averager_unit pmba_checker u_pmba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
